@@ design/vcm_pkg.sv @@
// types and constants shared by the voxel checkerboard modulator
// no dependencies; imported by voxel_checkerboard_modulator

package vcm_pkg;

   localparam int POSITION_WIDTH = 24;
   localparam int VALUE_W        = 32;
   localparam int CSR_W          = 64;
   localparam int ORIGIN_W       = 24;
   localparam int GEO_W          = 20;
   localparam int ORIGIN_LSB     = 40;
   localparam int WIDTH_LSB      = 20;
   localparam int AMP_W          = 16;
   localparam int FAC_W          = 17;
   localparam int AXES           = 3;
   localparam int DIFF_W         = 25;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [15:0] Q15_ONE     = 16'h8000;

   typedef enum logic [1:0] {
      CSR_GEOMETRY_X = 2'd0,
      CSR_GEOMETRY_Y = 2'd1,
      CSR_GEOMETRY_Z = 2'd2,
      CSR_AMPLITUDE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]        voxel_value;
      logic signed [POSITION_WIDTH-1:0] pos_x;
      logic signed [POSITION_WIDTH-1:0] pos_y;
      logic signed [POSITION_WIDTH-1:0] pos_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] modulated_value;
      logic                      saturated;
   } rsp_payload_type;

endpackage

@@ design/voxel_checkerboard_modulator.sv @@
// voxel checkerboard modulator: pipelined per-axis cell division, sine lookup and gain
// depends on vcm_pkg
//
// Usage: each transfer on the req channel carries a voxel value and its x, y, z position
// (Q16.8). Exactly one transfer leaves on the rsp channel per input, in order: the value
// scaled by one plus amplitude times the three axis checkerboard factors, rounded and
// saturated to 32 bits, with a flag when it was clipped.
// The csr port is a plain write port (registers geometry_x/y/z and amplitude); write it
// only while no item is in flight.
// The cell division runs one quotient bit per stage over 25 stages and the sine index
// division one bit per stage; after the table read come four gain stages and two
// rounding stages.
// Throughput: one item per cycle, unless a held result stalls the pipeline.
// Reset clears all valid bits and all csr registers; the pipeline is empty afterwards.
// When the receiver stalls, the finished result waits in the output register while
// the pipeline keeps moving and filling bubbles; req_ready falls only once an item
// reaches the last stage behind a held result.

module voxel_checkerboard_modulator #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  vcm_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output vcm_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_wr_en,
   input  vcm_pkg::csr_index_type        csr_index,
   input  logic [vcm_pkg::CSR_W-1:0]     csr_wdata
);
   import vcm_pkg::*;

   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int NPROD_W = GEO_W + IDX_W;
   localparam int PROD_W  = 64;
   localparam int R1_W    = PROD_W - 15;
   localparam int R2_W    = R1_W - 15;

   function automatic logic [15:0] sine_entry(input int k);
      logic [63:0]        u;
      logic [63:0]        theta;
      logic [63:0]        th2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      logic signed [63:0] s;
      u     = (64'(k) << 30) / SINE_TABLE_DEPTH;
      theta = (u * HALF_PI_Q30) >> 30;
      th2   = (theta * theta) >> 30;
      term  = theta;
      acc   = $signed(theta);
      term  = ((term * th2) >> 30) / 64'd6;
      acc   = acc - $signed(term);
      term  = ((term * th2) >> 30) / 64'd20;
      acc   = acc + $signed(term);
      term  = ((term * th2) >> 30) / 64'd42;
      acc   = acc - $signed(term);
      term  = ((term * th2) >> 30) / 64'd72;
      acc   = acc + $signed(term);
      term  = ((term * th2) >> 30) / 64'd110;
      acc   = acc - $signed(term);
      if (acc < 0) begin
         acc = '0;
      end
      s = (acc + 64'sd16384) >>> 15;
      if (s > 64'sd32768) begin
         s = 64'sd32768;
      end
      return s[15:0];
   endfunction

   // quarter-wave sine table
   logic [15:0] sine_rom [SINE_TABLE_DEPTH];
   for (genvar gk = 0; gk < SINE_TABLE_DEPTH; gk++) begin : g_rom
      localparam logic [15:0] Entry = sine_entry(gk);
      assign sine_rom[gk] = Entry;
   end

   // csr registers
   logic [CSR_W-1:0]        geometry_ff [AXES];
   logic signed [AMP_W-1:0] amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            geometry_ff[a] <= '0;
         end
         amplitude_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GEOMETRY_X: geometry_ff[0] <= csr_wdata;
            CSR_GEOMETRY_Y: geometry_ff[1] <= csr_wdata;
            CSR_GEOMETRY_Z: geometry_ff[2] <= csr_wdata;
            CSR_AMPLITUDE:  amplitude_ff   <= csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   logic signed [ORIGIN_W-1:0] origin  [AXES];
   logic [GEO_W-1:0]           cell_w  [AXES];
   logic [GEO_W-1:0]           trans_w [AXES];
   logic signed [POSITION_WIDTH-1:0] pos_in [AXES];

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         origin[a]  = geometry_ff[a][ORIGIN_LSB +: ORIGIN_W];
         cell_w[a]  = geometry_ff[a][WIDTH_LSB +: GEO_W];
         trans_w[a] = geometry_ff[a][GEO_W-1:0];
      end
      pos_in[0] = req_payload.pos_x;
      pos_in[1] = req_payload.pos_y;
      pos_in[2] = req_payload.pos_z;
   end

   // pipeline advance
   logic adv;
   logic r1_valid_ff;
   logic rsp_valid_ff;

   assign adv       = !(r1_valid_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready = adv;

   // cell division stages, stage 0 holds offset magnitude
   logic                      dv_valid_ff [DIFF_W+1];
   logic                      dv_valid_in [DIFF_W+1];
   logic signed [VALUE_W-1:0] dv_value_ff [DIFF_W+1];
   logic signed [VALUE_W-1:0] dv_value_in [DIFF_W+1];
   logic [DIFF_W-1:0]         dv_mag_ff   [DIFF_W+1][AXES];
   logic [DIFF_W-1:0]         dv_mag_in   [DIFF_W+1][AXES];
   logic [GEO_W-1:0]          dv_rem_ff   [DIFF_W+1][AXES];
   logic [GEO_W-1:0]          dv_rem_in   [DIFF_W+1][AXES];
   logic                      dv_neg_ff   [DIFF_W+1][AXES];
   logic                      dv_neg_in   [DIFF_W+1][AXES];
   logic                      dv_qlsb_ff  [DIFF_W+1][AXES];
   logic                      dv_qlsb_in  [DIFF_W+1][AXES];

   always_comb begin : p_div
      logic signed [DIFF_W-1:0] diff;
      logic [GEO_W:0]           shv;
      logic                     ge;
      dv_valid_in[0] = req_valid;
      dv_value_in[0] = req_payload.voxel_value;
      for (int a = 0; a < AXES; a++) begin
         diff = DIFF_W'(pos_in[a]) - DIFF_W'(origin[a]);
         dv_neg_in[0][a]  = diff[DIFF_W-1];
         dv_mag_in[0][a]  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
         dv_rem_in[0][a]  = '0;
         dv_qlsb_in[0][a] = 1'b0;
      end
      for (int s = 1; s <= DIFF_W; s++) begin
         dv_valid_in[s] = dv_valid_ff[s-1];
         dv_value_in[s] = dv_value_ff[s-1];
         for (int a = 0; a < AXES; a++) begin
            shv = {dv_rem_ff[s-1][a], dv_mag_ff[s-1][a][DIFF_W-1]};
            ge  = shv >= {1'b0, cell_w[a]};
            dv_rem_in[s][a]  = ge ? GEO_W'(shv - {1'b0, cell_w[a]}) : GEO_W'(shv);
            dv_mag_in[s][a]  = dv_mag_ff[s-1][a] << 1;
            dv_neg_in[s][a]  = dv_neg_ff[s-1][a];
            dv_qlsb_in[s][a] = ge;
         end
      end
   end

   // floor fixup of remainder and parity
   logic                      f1_valid_ff;
   logic signed [VALUE_W-1:0] f1_value_ff;
   logic [GEO_W-1:0]          f1_rem_ff [AXES];
   logic [GEO_W-1:0]          f1_rem_in [AXES];
   logic                      f1_odd_ff [AXES];
   logic                      f1_odd_in [AXES];

   always_comb begin : p_fix
      logic wrap;
      for (int a = 0; a < AXES; a++) begin
         wrap = dv_neg_ff[DIFF_W][a] && (dv_rem_ff[DIFF_W][a] != '0);
         f1_rem_in[a] = wrap ? GEO_W'(cell_w[a] - dv_rem_ff[DIFF_W][a])
                             : dv_rem_ff[DIFF_W][a];
         f1_odd_in[a] = dv_qlsb_ff[DIFF_W][a] ^ wrap;
      end
   end

   // sine index division stages, stage 0 holds the scaled edge distance
   logic                      ix_valid_ff [IDX_W+1];
   logic                      ix_valid_in [IDX_W+1];
   logic signed [VALUE_W-1:0] ix_value_ff [IDX_W+1];
   logic signed [VALUE_W-1:0] ix_value_in [IDX_W+1];
   logic [GEO_W-1:0]          ix_rem_ff   [IDX_W+1][AXES];
   logic [GEO_W-1:0]          ix_rem_in   [IDX_W+1][AXES];
   logic [IDX_W-1:0]          ix_low_ff   [IDX_W+1][AXES];
   logic [IDX_W-1:0]          ix_low_in   [IDX_W+1][AXES];
   logic [IDX_W-1:0]          ix_q_ff     [IDX_W+1][AXES];
   logic [IDX_W-1:0]          ix_q_in     [IDX_W+1][AXES];
   logic                      ix_flat_ff  [IDX_W+1][AXES];
   logic                      ix_flat_in  [IDX_W+1][AXES];
   logic                      ix_unit_ff  [IDX_W+1][AXES];
   logic                      ix_unit_in  [IDX_W+1][AXES];
   logic                      ix_odd_ff   [IDX_W+1][AXES];
   logic                      ix_odd_in   [IDX_W+1][AXES];

   always_comb begin : p_idx
      logic [GEO_W-1:0]   num;
      logic [NPROD_W-1:0] nprod;
      logic [GEO_W:0]     shv;
      logic               ge;
      ix_valid_in[0] = f1_valid_ff;
      ix_value_in[0] = f1_value_ff;
      for (int a = 0; a < AXES; a++) begin
         num   = (f1_rem_ff[a] < trans_w[a]) ? f1_rem_ff[a]
                                             : GEO_W'(cell_w[a] - f1_rem_ff[a]);
         nprod = NPROD_W'(num) * NPROD_W'(SINE_TABLE_DEPTH);
         ix_rem_in[0][a]  = nprod[NPROD_W-1 -: GEO_W];
         ix_low_in[0][a]  = nprod[IDX_W-1:0];
         ix_q_in[0][a]    = '0;
         ix_flat_in[0][a] = (f1_rem_ff[a] >= trans_w[a]) &&
                            (({1'b0, f1_rem_ff[a]} + {1'b0, trans_w[a]}) <= {1'b0, cell_w[a]});
         ix_unit_in[0][a] = (cell_w[a] == '0);
         ix_odd_in[0][a]  = f1_odd_ff[a];
      end
      for (int s = 1; s <= IDX_W; s++) begin
         ix_valid_in[s] = ix_valid_ff[s-1];
         ix_value_in[s] = ix_value_ff[s-1];
         for (int a = 0; a < AXES; a++) begin
            shv = {ix_rem_ff[s-1][a], ix_low_ff[s-1][a][IDX_W-1]};
            ge  = shv >= {1'b0, trans_w[a]};
            ix_rem_in[s][a]  = ge ? GEO_W'(shv - {1'b0, trans_w[a]}) : GEO_W'(shv);
            ix_low_in[s][a]  = ix_low_ff[s-1][a] << 1;
            ix_q_in[s][a]    = {ix_q_ff[s-1][a][IDX_W-2:0], ge};
            ix_flat_in[s][a] = ix_flat_ff[s-1][a];
            ix_unit_in[s][a] = ix_unit_ff[s-1][a];
            ix_odd_in[s][a]  = ix_odd_ff[s-1][a];
         end
      end
   end

   // table read and axis factor
   logic                      lu_valid_ff;
   logic signed [VALUE_W-1:0] lu_value_ff;
   logic signed [FAC_W-1:0]   lu_fac_ff [AXES];
   logic signed [FAC_W-1:0]   lu_fac_in [AXES];

   always_comb begin : p_lut
      logic [FAC_W-1:0] mag;
      for (int a = 0; a < AXES; a++) begin
         if (ix_unit_ff[IDX_W][a] || ix_flat_ff[IDX_W][a]) begin
            mag = FAC_W'(Q15_ONE);
         end else begin
            mag = FAC_W'(sine_rom[ix_q_ff[IDX_W][a]]);
         end
         lu_fac_in[a] = (!ix_unit_ff[IDX_W][a] && ix_odd_ff[IDX_W][a]) ? -$signed(mag)
                                                                         : $signed(mag);
      end
   end

   // gain multiply and rounding stages
   logic                      m1_valid_ff;
   logic signed [VALUE_W-1:0] m1_value_ff;
   logic signed [31:0]        m1_fxy_ff;
   logic signed [31:0]        m1_fza_ff;
   logic                      m2_valid_ff;
   logic signed [VALUE_W-1:0] m2_value_ff;
   logic signed [PROD_W-1:0]  m2_p_ff;
   logic                      m3_valid_ff;
   logic signed [VALUE_W-1:0] m3_value_ff;
   logic [31:0]               m3_m30_ff;
   logic                      m4_valid_ff;
   logic signed [PROD_W-1:0]  m4_prod_ff;
   logic signed [R1_W-1:0]    r1_value_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_sat_ff;

   logic signed [31:0]        m1_fxy_in;
   logic signed [31:0]        m1_fza_in;
   logic signed [PROD_W-1:0]  m2_p_in;
   logic [31:0]               m3_m30_in;
   logic signed [PROD_W-1:0]  m4_prod_in;
   logic signed [R1_W-1:0]    r1_value_in;
   logic signed [VALUE_W-1:0] rsp_value_in;
   logic                      rsp_sat_in;

   always_comb begin : p_gain
      logic signed [PROD_W-1:0] m;
      logic signed [PROD_W-1:0] r1_sum;
      logic signed [R2_W-1:0]   r2;
      m1_fxy_in  = 32'(lu_fac_ff[0] * lu_fac_ff[1]);
      m1_fza_in  = 32'(lu_fac_ff[2] * amplitude_ff);
      m2_p_in    = PROD_W'(m1_fxy_ff * m1_fza_ff);
      m          = m2_p_ff + (64'sd1 <<< 60) + (64'sd1 <<< 29);
      m3_m30_in  = m[61:30];
      m4_prod_in = PROD_W'(m3_value_ff * $signed({1'b0, m3_m30_ff}));
      r1_sum     = (m4_prod_ff + 64'sd16384) >>> 15;
      r1_value_in = R1_W'(r1_sum);
      r2 = R2_W'((r1_value_ff + R1_W'(16384)) >>> 15);
      if (r2 > R2_W'(32'sh7fffffff)) begin
         rsp_value_in = 32'sh7fffffff;
         rsp_sat_in   = 1'b1;
      end else if (r2 < R2_W'(32'sh80000000)) begin
         rsp_value_in = 32'sh80000000;
         rsp_sat_in   = 1'b1;
      end else begin
         rsp_value_in = VALUE_W'(r2);
         rsp_sat_in   = 1'b0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIFF_W; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
         for (int s = 0; s <= IDX_W; s++) begin
            ix_valid_ff[s] <= 1'b0;
         end
         f1_valid_ff  <= 1'b0;
         lu_valid_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         m4_valid_ff  <= 1'b0;
         r1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            for (int s = 0; s <= DIFF_W; s++) begin
               dv_valid_ff[s] <= dv_valid_in[s];
            end
            for (int s = 0; s <= IDX_W; s++) begin
               ix_valid_ff[s] <= ix_valid_in[s];
            end
            f1_valid_ff <= dv_valid_ff[DIFF_W];
            lu_valid_ff <= ix_valid_ff[IDX_W];
            m1_valid_ff <= lu_valid_ff;
            m2_valid_ff <= m1_valid_ff;
            m3_valid_ff <= m2_valid_ff;
            m4_valid_ff <= m3_valid_ff;
            r1_valid_ff <= m4_valid_ff;
         end
         if (adv && r1_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= DIFF_W; s++) begin
            dv_value_ff[s] <= dv_value_in[s];
            for (int a = 0; a < AXES; a++) begin
               dv_mag_ff[s][a]  <= dv_mag_in[s][a];
               dv_rem_ff[s][a]  <= dv_rem_in[s][a];
               dv_neg_ff[s][a]  <= dv_neg_in[s][a];
               dv_qlsb_ff[s][a] <= dv_qlsb_in[s][a];
            end
         end
         f1_value_ff <= dv_value_ff[DIFF_W];
         for (int a = 0; a < AXES; a++) begin
            f1_rem_ff[a] <= f1_rem_in[a];
            f1_odd_ff[a] <= f1_odd_in[a];
         end
         for (int s = 0; s <= IDX_W; s++) begin
            ix_value_ff[s] <= ix_value_in[s];
            for (int a = 0; a < AXES; a++) begin
               ix_rem_ff[s][a]  <= ix_rem_in[s][a];
               ix_low_ff[s][a]  <= ix_low_in[s][a];
               ix_q_ff[s][a]    <= ix_q_in[s][a];
               ix_flat_ff[s][a] <= ix_flat_in[s][a];
               ix_unit_ff[s][a] <= ix_unit_in[s][a];
               ix_odd_ff[s][a]  <= ix_odd_in[s][a];
            end
         end
         lu_value_ff <= ix_value_ff[IDX_W];
         for (int a = 0; a < AXES; a++) begin
            lu_fac_ff[a] <= lu_fac_in[a];
         end
         m1_value_ff <= lu_value_ff;
         m1_fxy_ff   <= m1_fxy_in;
         m1_fza_ff   <= m1_fza_in;
         m2_value_ff <= m1_value_ff;
         m2_p_ff     <= m2_p_in;
         m3_value_ff <= m2_value_ff;
         m3_m30_ff   <= m3_m30_in;
         m4_prod_ff  <= m4_prod_in;
         r1_value_ff <= r1_value_in;
      end
      if (adv && r1_valid_ff) begin
         rsp_value_ff <= rsp_value_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_payload.modulated_value = rsp_value_ff;
   assign rsp_payload.saturated       = rsp_sat_ff;

endmodule
